// ===== hw/rtl/btans_pkg.sv =====
// Shared types and constant coding tables for the binary tANS encoder.
// Used by btans_step, btans_out_queue and binary_tans_encoder_core.
// Depends on nothing.
package btans_pkg;

    localparam int SPLIT_MAX = 6;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef logic [2:0] t_state;
    typedef logic [2:0] t_split;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_entry;

    typedef struct packed {
        logic [1:0] num;
        t_entry     ent0;
        t_entry     ent1;
    } t_push;

    // Next-state offsets indexed by symbol, split row and state offset.
    localparam logic [2:0] NEXT_TAB [0:1][0:SPLIT_MAX][0:7] = '{
        '{
            '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd0},
            '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
            '{3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd0, 3'd1, 3'd1},
            '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1},
            '{3'd3, 3'd4, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2},
            '{3'd1, 3'd1, 3'd2, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0},
            '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3}
        },
        '{
            '{3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7},
            '{3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd1, 3'd1},
            '{3'd6, 3'd6, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7},
            '{3'd4, 3'd5, 3'd6, 3'd7, 3'd2, 3'd2, 3'd3, 3'd3},
            '{3'd6, 3'd6, 3'd7, 3'd7, 3'd5, 3'd5, 3'd5, 3'd5},
            '{3'd6, 3'd7, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5},
            '{3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6, 3'd7, 3'd7}
        }
    };

    // Emitted bit values indexed by symbol, split row and state offset.
    localparam logic [2:0] BITS_TAB [0:1][0:SPLIT_MAX][0:7] = '{
        '{
            '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1},
            '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7},
            '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd1},
            '{3'd0, 3'd2, 3'd1, 3'd3, 3'd0, 3'd2, 3'd1, 3'd3},
            '{3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1},
            '{3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd2, 3'd1, 3'd3},
            '{3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1}
        },
        '{
            '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7},
            '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1},
            '{3'd0, 3'd2, 3'd1, 3'd3, 3'd0, 3'd2, 3'd1, 3'd3},
            '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd1},
            '{3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd2, 3'd1, 3'd3},
            '{3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1},
            '{3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1}
        }
    };

    // Emitted bit counts indexed by symbol, split row and state offset.
    localparam logic [1:0] NBITS_TAB [0:1][0:SPLIT_MAX][0:7] = '{
        '{
            '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1},
            '{2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3},
            '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1},
            '{2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2},
            '{2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1},
            '{2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2},
            '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1}
        },
        '{
            '{2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3},
            '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1},
            '{2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2},
            '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1},
            '{2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2},
            '{2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1},
            '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1}
        }
    };

endpackage

// ===== hw/rtl/binary_tans_encoder_core.sv =====
// Top level of the binary tANS encoder: stream ports, coder and output queue.
// Depends on btans_pkg, btans_step and btans_out_queue.
//
//   channel   direction  carries
//   s_axis    in         tdata: symbol (bit 0); tuser: func (0 encode, 1 finish)
//   m_axis    out        tdata: out_byte; tlast: last
//   cfg       in         data: probability_split (3 bits, saturated to 6)
//
// An item is taken every cycle while the output queue has room for two bytes;
// its bytes are registered in the queue and go out on m_axis behind those waiting.
// A finish item may give two bytes, which leave one per cycle while m_axis is ready.
// The coder state, packer and queue are cleared by the synchronous reset.
// A stall on m_axis fills the queue and then holds s_axis_tready low.
module binary_tans_encoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // bit 0: symbol; bits 7..1: zero
    input  logic       i_s_axis_tuser,   // bit 0: func
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // bits 7..0: out_byte
    output logic       o_m_axis_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_data
);

    btans_pkg::t_push  push;
    btans_pkg::t_entry head;
    logic              accept;
    logic              space;
    logic              pop;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = space;
    assign accept          = i_s_axis_tvalid && space;
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = head.data;
    assign o_m_axis_tlast  = head.last;

    btans_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_func      (i_s_axis_tuser),
        .i_symbol    (i_s_axis_tdata[0]),
        .o_push      (push)
    );

    btans_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_space (space),
        .o_valid (o_m_axis_tvalid),
        .o_entry (head)
    );

`ifndef SYNTHESIS
    a_no_push_without_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> push.num == 2'd0)
        else $error("queue written without an accepted item");

    a_finish_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_s_axis_tuser == btans_pkg::FUNC_FINISH |=> o_m_axis_tvalid)
        else $error("finish item left no byte waiting");

    a_last_ends_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.num != 2'd0 && push.ent0.last |-> i_s_axis_tuser == btans_pkg::FUNC_FINISH)
        else $error("last byte pushed by an encode item");
`endif

endmodule

// ===== hw/rtl/btans_step.sv =====
// Coder state, split register and byte packer of the binary tANS encoder.
// Turns one accepted item into zero to two output entries combinationally, in the same cycle.
// Depends on btans_pkg.
module btans_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  btans_pkg::t_split     i_cfg_data,
    input  logic                  i_accept,
    input  logic                  i_func,
    input  logic                  i_symbol,
    output btans_pkg::t_push      o_push
);

    btans_pkg::t_split r_split;
    btans_pkg::t_split n_split;
    btans_pkg::t_state r_state;
    btans_pkg::t_state n_state;
    logic [7:0]        r_byte;
    logic [7:0]        n_byte;
    logic [2:0]        r_cnt;
    logic [2:0]        n_cnt;

    logic [2:0]  tab_val;
    logic [1:0]  tab_nb;
    logic [1:0]  align_sh;
    logic [3:0]  field;
    logic [2:0]  add_n;
    logic [3:0]  total;
    logic [15:0] acc;

    always_comb begin
        n_split = r_split;
        if (i_cfg_valid) begin
            n_split = (i_cfg_data > 3'(btans_pkg::SPLIT_MAX)) ?
                      3'(btans_pkg::SPLIT_MAX) : i_cfg_data;
        end
    end

    always_comb begin
        tab_val  = btans_pkg::BITS_TAB[i_symbol][r_split][r_state];
        tab_nb   = btans_pkg::NBITS_TAB[i_symbol][r_split][r_state];
        align_sh = 2'd3 - tab_nb;
        if (i_func == btans_pkg::FUNC_FINISH) begin
            field = {r_state, 1'b1};
            add_n = 3'd4;
        end else begin
            field = 4'({tab_val, 1'b0} << align_sh);
            add_n = {1'b0, tab_nb};
        end
        total = {1'b0, r_cnt} + {1'b0, add_n};
        acc   = {r_byte, 8'h00} | ({field, 12'h000} >> r_cnt);
    end

    always_comb begin
        o_push.ent0.data = acc[15:8];
        o_push.ent1.data = acc[7:0];
        o_push.ent1.last = 1'b1;
        o_push.num       = 2'd0;
        o_push.ent0.last = 1'b0;
        if (i_accept) begin
            if (i_func == btans_pkg::FUNC_FINISH) begin
                o_push.ent0.last = (total <= 4'd8);
                o_push.num       = (total > 4'd8) ? 2'd2 : 2'd1;
            end else begin
                o_push.num = (total >= 4'd8) ? 2'd1 : 2'd0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_byte  = r_byte;
        n_cnt   = r_cnt;
        if (i_accept) begin
            if (i_func == btans_pkg::FUNC_FINISH) begin
                n_state = '0;
                n_byte  = '0;
                n_cnt   = '0;
            end else begin
                n_state = btans_pkg::NEXT_TAB[i_symbol][r_split][r_state];
                if (total >= 4'd8) begin
                    n_byte = acc[7:0];
                    n_cnt  = 3'(total - 4'd8);
                end else begin
                    n_byte = acc[15:8];
                    n_cnt  = total[2:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= 3'(btans_pkg::SPLIT_MAX);
            r_state <= '0;
            r_byte  <= '0;
            r_cnt   <= '0;
        end else begin
            r_split <= n_split;
            r_state <= n_state;
            r_byte  <= n_byte;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_pad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte & (8'hFF >> r_cnt)) == 8'h00)
        else $error("pending byte holds bits below its fill level");

    a_finish_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_func == btans_pkg::FUNC_FINISH |=>
        r_state == '0 && r_cnt == '0 && r_byte == '0)
        else $error("finish did not return the coder to its start state");

    a_encode_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_func == btans_pkg::FUNC_ENCODE |->
        o_push.num != 2'd2 && !o_push.ent0.last)
        else $error("encode item produced more than one byte or a last byte");

    a_split_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_split <= 3'(btans_pkg::SPLIT_MAX))
        else $error("split register out of range");
`endif

endmodule

// ===== hw/rtl/btans_out_queue.sv =====
// Small output queue that takes up to two entries per cycle and gives one.
// Parts the coder from the output stream so input is taken while bytes wait.
// Depends on btans_pkg.
module btans_out_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  btans_pkg::t_push     i_push,
    input  logic                 i_pop,
    output logic                 o_space,
    output logic                 o_valid,
    output btans_pkg::t_entry    o_entry
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    btans_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     n_wr;
    logic [AW-1:0]     r_rd;
    logic [AW-1:0]     n_rd;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [AW-1:0]     wr_next;

    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign o_space = (r_count <= CW'(DEPTH - 2));
    assign wr_next = r_wr + AW'(1);

    always_comb begin
        n_wr    = r_wr + AW'(i_push.num);
        n_rd    = i_pop ? r_rd + AW'(1) : r_rd;
        n_count = r_count + CW'(i_push.num) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.ent0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.ent1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("output queue holds more entries than it has");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("output queue popped while empty");
`endif

endmodule
